// ===== rtl/ssrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted score record table package
// Shared widths, codes, the record type and small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssrt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int NUM_BUCKETS  = 5;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 16;
  localparam int SCORE_W = 10;
  localparam int SUM_W   = 11;
  localparam int STAT_W  = 2;
  localparam int BKT_W   = 3;
  localparam int CNT_W   = 7;
  localparam int CFG_IW  = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HIST   = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_LIMIT_ONE   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_LIMIT_TWO   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LIMIT_THREE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LIMIT_FOUR  = 3'd3;

  // Reset values of the bucket limits
  localparam logic [SUM_W-1:0] LIMIT_ONE_RST   = 11'd1180;
  localparam logic [SUM_W-1:0] LIMIT_TWO_RST   = 11'd1380;
  localparam logic [SUM_W-1:0] LIMIT_THREE_RST = 11'd1580;
  localparam logic [SUM_W-1:0] LIMIT_FOUR_RST  = 11'd1780;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] first;
    logic [SCORE_W-1:0] second;
  } rec_t;

  // Sum of both scores of a record.
  function automatic logic [SUM_W-1:0] rec_sum(input rec_t r);
    return SUM_W'(r.first) + SUM_W'(r.second);
  endfunction

  // Bucket of a sum; the limits are tested in register order.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] l0,
                                                 input logic [SUM_W-1:0] l1,
                                                 input logic [SUM_W-1:0] l2,
                                                 input logic [SUM_W-1:0] l3);
    logic [BKT_W-1:0] b;
    if (s <= l0) b = 3'd0;
    else if (s <= l1) b = 3'd1;
    else if (s <= l2) b = 3'd2;
    else if (s <= l3) b = 3'd3;
    else b = 3'd4;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ssrt_if.sv =====
// ----------------------------------------------------------------------------
// Sorted score record table channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssrt_in_if;
  logic                            valid;
  logic                            ready;
  logic [ssrt_pkg::CMD_W-1:0]      cmd;
  logic [ssrt_pkg::ID_W-1:0]       record_id;
  logic [ssrt_pkg::SCORE_W-1:0]    first_score;
  logic [ssrt_pkg::SCORE_W-1:0]    second_score;
  modport source (output valid, cmd, record_id, first_score, second_score, input ready);
  modport sink (input valid, cmd, record_id, first_score, second_score, output ready);
endinterface

interface ssrt_out_if;
  logic                            valid;
  logic                            ready;
  logic [ssrt_pkg::STAT_W-1:0]     status;
  logic [ssrt_pkg::ID_W-1:0]       out_id;
  logic [ssrt_pkg::SCORE_W-1:0]    out_first;
  logic [ssrt_pkg::SCORE_W-1:0]    out_second;
  logic [ssrt_pkg::SUM_W-1:0]      out_sum;
  logic [ssrt_pkg::BKT_W-1:0]      bucket_index;
  logic [ssrt_pkg::CNT_W-1:0]      count_value;
  logic                            last;
  modport source (output valid, status, out_id, out_first, out_second, out_sum,
                  bucket_index, count_value, last, input ready);
  modport sink (input valid, status, out_id, out_first, out_second, out_sum,
                bucket_index, count_value, last, output ready);
endinterface

interface ssrt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ssrt_pkg::CFG_IW-1:0]     reg_index;
  logic [ssrt_pkg::SUM_W-1:0]      wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssrt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssrt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_score_record_table.sv =====
// ----------------------------------------------------------------------------
// Sorted score record table
// A table of id/score records kept in one RAM and worked on by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one command beat at a time (append, sorted insert, delete,
//   find, sort and list, histogram); ready is high only while the block is
//   idle. out_ch carries the result beats, the final one with last set.
//   cfg_ch writes the four bucket limits at any time and is always ready.
// Sequencing:
//   Each entry visited is read once through the single RAM read port with
//   registered data. Histogram gives five beats, one per bucket, and sort
//   and list gives one beat per entry. A result beat held back by the
//   receiver stalls the sequencer. The next command is taken once the last
//   beat is loaded.
// Reset:
//   rst_n empties the table and loads the default limits; no clearing pass
//   is run and the RAM contents are simply ignored until written.
// Stalls:
//   A single output register holds each result beat; the sequencer waits
//   while the receiver holds ready low, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_score_record_table #(
  parameter int CAPACITY = ssrt_pkg::CAPACITY_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ssrt_in_if.sink    in_ch,
  ssrt_out_if.source out_ch,
  ssrt_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $bits(ssrt_pkg::rec_t);

  typedef enum logic [15:0] {
    ST_IDLE       = 16'b0000_0000_0000_0001,
    ST_SCAN_RD    = 16'b0000_0000_0000_0010,
    ST_SCAN_CHK   = 16'b0000_0000_0000_0100,
    ST_SHIFT_RD   = 16'b0000_0000_0000_1000,
    ST_SHIFT_WR   = 16'b0000_0000_0001_0000,
    ST_PUT        = 16'b0000_0000_0010_0000,
    ST_SORT_OUTER = 16'b0000_0000_0100_0000,
    ST_SORT_FIRST = 16'b0000_0000_1000_0000,
    ST_SORT_RD    = 16'b0000_0001_0000_0000,
    ST_SORT_CHK   = 16'b0000_0010_0000_0000,
    ST_SWAP_A     = 16'b0000_0100_0000_0000,
    ST_SWAP_B     = 16'b0000_1000_0000_0000,
    ST_LIST_RD    = 16'b0001_0000_0000_0000,
    ST_LIST_EMIT  = 16'b0010_0000_0000_0000,
    ST_HIST_EMIT  = 16'b0100_0000_0000_0000,
    ST_REPLY      = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  ssrt_pkg::rec_t key_r, key_nxt;
  ssrt_pkg::rec_t hold_r, hold_nxt;
  ssrt_pkg::rec_t min_r, min_nxt;
  ssrt_pkg::rec_t reci_r, reci_nxt;
  ssrt_pkg::rec_t key_in;
  ssrt_pkg::rec_t rd_rec;

  logic [ssrt_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ssrt_pkg::STAT_W-1:0] st_r, st_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic [CW-1:0]               idx_dec;
  logic [CW-1:0]               idx_inc;
  logic [CW-1:0]               i_inc;
  logic [ssrt_pkg::BKT_W-1:0]  b_r, b_nxt;
  logic [ssrt_pkg::BKT_W-1:0]  bkt;
  logic [ssrt_pkg::CNT_W-1:0]  hcnt_r [ssrt_pkg::NUM_BUCKETS];
  logic [ssrt_pkg::CNT_W-1:0]  hcnt_nxt [ssrt_pkg::NUM_BUCKETS];
  logic [ssrt_pkg::SUM_W-1:0]  lim_r [4];
  logic [ssrt_pkg::SUM_W-1:0]  key_sum;

  // Output register
  logic                        out_vld_r, out_vld_nxt;
  logic [ssrt_pkg::STAT_W-1:0] o_st_r, o_st_nxt;
  ssrt_pkg::rec_t              o_rec_r, o_rec_nxt;
  logic [ssrt_pkg::BKT_W-1:0]  o_bkt_r, o_bkt_nxt;
  logic [ssrt_pkg::CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic                        o_last_r, o_last_nxt;
  logic                        out_free;

  // RAM port signals
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;

  ssrt_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and helper values.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_vld_r || out_ch.ready;
  assign rd_rec       = ssrt_pkg::rec_t'(rd_data);
  assign key_sum      = ssrt_pkg::rec_sum(key_r);
  assign idx_dec      = idx_r - CW'(1);
  assign idx_inc      = idx_r + CW'(1);
  assign i_inc        = i_r + CW'(1);
  assign bkt          = ssrt_pkg::bucket_of(ssrt_pkg::rec_sum(rd_rec),
                                            lim_r[0], lim_r[1], lim_r[2], lim_r[3]);

  always_comb begin
    key_in.id     = in_ch.record_id;
    key_in.first  = in_ch.first_score;
    key_in.second = in_ch.second_score;
  end

  // Result beat outputs.
  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = o_st_r;
  assign out_ch.out_id       = o_rec_r.id;
  assign out_ch.out_first    = o_rec_r.first;
  assign out_ch.out_second   = o_rec_r.second;
  assign out_ch.out_sum      = ssrt_pkg::rec_sum(o_rec_r);
  assign out_ch.bucket_index = o_bkt_r;
  assign out_ch.count_value  = o_cnt_r;
  assign out_ch.last         = o_last_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    hold_nxt  = hold_r;
    min_nxt   = min_r;
    reci_nxt  = reci_r;
    cmd_nxt   = cmd_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    hcnt_nxt  = hcnt_r;

    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = RW'(min_r);

    out_vld_nxt = out_vld_r && !out_ch.ready;
    o_st_nxt    = o_st_r;
    o_rec_nxt   = o_rec_r;
    o_bkt_nxt   = o_bkt_r;
    o_cnt_nxt   = o_cnt_r;
    o_last_nxt  = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          key_nxt = key_in;
          cmd_nxt = in_ch.cmd;
          idx_nxt = '0;
          b_nxt   = '0;
          for (int b = 0; b < ssrt_pkg::NUM_BUCKETS; b++) begin
            hcnt_nxt[b] = '0;
          end
          case (in_ch.cmd)
            ssrt_pkg::CMD_APPEND, ssrt_pkg::CMD_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                st_nxt    = ssrt_pkg::STAT_FULL;
                hold_nxt  = key_in;
                state_nxt = ST_REPLY;
              end else if (in_ch.cmd == ssrt_pkg::CMD_APPEND) begin
                pos_nxt   = cnt_r;
                state_nxt = ST_PUT;
              end else begin
                state_nxt = ST_SCAN_RD;
              end
            end
            ssrt_pkg::CMD_DELETE, ssrt_pkg::CMD_FIND, ssrt_pkg::CMD_HIST: begin
              state_nxt = ST_SCAN_RD;
            end
            ssrt_pkg::CMD_SORT: begin
              if (cnt_r == '0) begin
                st_nxt    = ssrt_pkg::STAT_EMPTY;
                hold_nxt  = '0;
                state_nxt = ST_REPLY;
              end else begin
                i_nxt     = '0;
                state_nxt = ST_SORT_OUTER;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Linear walk used by insert, delete, find and histogram.
      ST_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          case (cmd_r)
            ssrt_pkg::CMD_INSERT: begin
              pos_nxt   = cnt_r;
              state_nxt = ST_PUT;
            end
            ssrt_pkg::CMD_HIST: begin
              state_nxt = ST_HIST_EMIT;
            end
            default: begin
              st_nxt        = ssrt_pkg::STAT_NOT_FOUND;
              hold_nxt      = '0;
              hold_nxt.id   = key_r.id;
              state_nxt     = ST_REPLY;
            end
          endcase
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        case (cmd_r)
          ssrt_pkg::CMD_INSERT: begin
            if (ssrt_pkg::rec_sum(rd_rec) >= key_sum) begin
              pos_nxt   = idx_r;
              idx_nxt   = cnt_r;
              state_nxt = ST_SHIFT_RD;
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = ST_SCAN_RD;
            end
          end
          ssrt_pkg::CMD_HIST: begin
            for (int b = 0; b < ssrt_pkg::NUM_BUCKETS; b++) begin
              if (bkt == ssrt_pkg::BKT_W'(b)) begin
                hcnt_nxt[b] = hcnt_r[b] + ssrt_pkg::CNT_W'(1);
              end
            end
            idx_nxt   = idx_inc;
            state_nxt = ST_SCAN_RD;
          end
          default: begin
            idx_nxt = idx_inc;
            if (rd_rec.id == key_r.id) begin
              hold_nxt = rd_rec;
              st_nxt   = ssrt_pkg::STAT_OK;
              if (cmd_r == ssrt_pkg::CMD_FIND) begin
                state_nxt = ST_REPLY;
              end else begin
                state_nxt = ST_SHIFT_RD;
              end
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end
        endcase
      end

      // Entry moves: upwards for insert, downwards for delete.
      ST_SHIFT_RD: begin
        if (cmd_r == ssrt_pkg::CMD_INSERT) begin
          if (idx_r == pos_r) begin
            state_nxt = ST_PUT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_dec[AW-1:0];
            state_nxt = ST_SHIFT_WR;
          end
        end else begin
          if (idx_r == cnt_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = ST_REPLY;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_SHIFT_WR;
          end
        end
      end

      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (cmd_r == ssrt_pkg::CMD_INSERT) begin
          wr_addr = idx_r[AW-1:0];
          idx_nxt = idx_dec;
        end else begin
          wr_addr = idx_dec[AW-1:0];
          idx_nxt = idx_inc;
        end
        state_nxt = ST_SHIFT_RD;
      end

      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        wr_data   = RW'(key_r);
        cnt_nxt   = cnt_r + CW'(1);
        hold_nxt  = key_r;
        st_nxt    = ssrt_pkg::STAT_OK;
        state_nxt = ST_REPLY;
      end

      // Selection sort: one pass per outer position.
      ST_SORT_OUTER: begin
        if (i_inc >= cnt_r) begin
          idx_nxt   = '0;
          state_nxt = ST_LIST_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          idx_nxt   = i_inc;
          state_nxt = ST_SORT_FIRST;
        end
      end

      ST_SORT_FIRST: begin
        reci_nxt  = rd_rec;
        min_nxt   = rd_rec;
        k_nxt     = i_r;
        state_nxt = ST_SORT_RD;
      end

      ST_SORT_RD: begin
        if (idx_r == cnt_r) begin
          if (k_r != i_r) begin
            state_nxt = ST_SWAP_A;
          end else begin
            i_nxt     = i_inc;
            state_nxt = ST_SORT_OUTER;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_SORT_CHK;
        end
      end

      ST_SORT_CHK: begin
        if (ssrt_pkg::rec_sum(min_r) > ssrt_pkg::rec_sum(rd_rec)) begin
          min_nxt = rd_rec;
          k_nxt   = idx_r;
        end
        idx_nxt   = idx_inc;
        state_nxt = ST_SORT_RD;
      end

      ST_SWAP_A: begin
        wr_en     = 1'b1;
        wr_addr   = i_r[AW-1:0];
        wr_data   = RW'(min_r);
        state_nxt = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[AW-1:0];
        wr_data   = RW'(reci_r);
        i_nxt     = i_inc;
        state_nxt = ST_SORT_OUTER;
      end

      // Listing of the sorted table.
      ST_LIST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_LIST_EMIT;
      end

      ST_LIST_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_st_nxt    = ssrt_pkg::STAT_OK;
          o_rec_nxt   = rd_rec;
          o_bkt_nxt   = '0;
          o_cnt_nxt   = ssrt_pkg::CNT_W'(cnt_r);
          o_last_nxt  = (idx_inc == cnt_r);
          if (idx_inc == cnt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_LIST_RD;
          end
        end
      end

      ST_HIST_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_st_nxt    = ssrt_pkg::STAT_OK;
          o_rec_nxt   = '0;
          o_bkt_nxt   = b_r;
          o_cnt_nxt   = hcnt_r[b_r];
          o_last_nxt  = (b_r == ssrt_pkg::BKT_W'(ssrt_pkg::NUM_BUCKETS - 1));
          b_nxt       = b_r + ssrt_pkg::BKT_W'(1);
          if (b_r == ssrt_pkg::BKT_W'(ssrt_pkg::NUM_BUCKETS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_st_nxt    = st_r;
          o_rec_nxt   = hold_r;
          o_bkt_nxt   = '0;
          o_cnt_nxt   = ssrt_pkg::CNT_W'(cnt_r);
          o_last_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      lim_r[0]  <= ssrt_pkg::LIMIT_ONE_RST;
      lim_r[1]  <= ssrt_pkg::LIMIT_TWO_RST;
      lim_r[2]  <= ssrt_pkg::LIMIT_THREE_RST;
      lim_r[3]  <= ssrt_pkg::LIMIT_FOUR_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          ssrt_pkg::CFG_LIMIT_ONE:   lim_r[0] <= cfg_ch.wr_data;
          ssrt_pkg::CFG_LIMIT_TWO:   lim_r[1] <= cfg_ch.wr_data;
          ssrt_pkg::CFG_LIMIT_THREE: lim_r[2] <= cfg_ch.wr_data;
          ssrt_pkg::CFG_LIMIT_FOUR:  lim_r[3] <= cfg_ch.wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    hold_r   <= hold_nxt;
    min_r    <= min_nxt;
    reci_r   <= reci_nxt;
    cmd_r    <= cmd_nxt;
    st_r     <= st_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    b_r      <= b_nxt;
    hcnt_r   <= hcnt_nxt;
    o_st_r   <= o_st_nxt;
    o_rec_r  <= o_rec_nxt;
    o_bkt_r  <= o_bkt_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
  end

`ifndef SYNTHESIS
  // The table never holds more than its capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The entry count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("entry count jumped");

  // The table is only written while a command is in progress.
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_ch.ready)
    else $error("table written while idle");
`endif

endmodule

`default_nettype wire
